[hw/rtl/ctt_pkg.sv]
// shared types and constants for the configuration text tokenizer
package ctt_pkg;

  // token kinds as carried on the result channel
  localparam logic [3:0] KIND_NEWLINE = 4'd0;
  localparam logic [3:0] KIND_SEMI    = 4'd1;
  localparam logic [3:0] KIND_LBRACK  = 4'd2;
  localparam logic [3:0] KIND_RBRACK  = 4'd3;
  localparam logic [3:0] KIND_ASSIGN  = 4'd4;
  localparam logic [3:0] KIND_COMMENT = 4'd5;
  localparam logic [3:0] KIND_STRING  = 4'd6;
  localparam logic [3:0] KIND_INTEGER = 4'd7;
  localparam logic [3:0] KIND_FLOAT   = 4'd8;
  localparam logic [3:0] KIND_IDENT   = 4'd9;
  localparam logic [3:0] KIND_BOOL    = 4'd10;
  localparam logic [3:0] KIND_INVALID = 4'd11;

  localparam int unsigned KIND_BITS = 4;
  localparam int unsigned LINE_BITS = 16;

  // character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_DQUOT = 8'h22;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SQUOT = 8'h27;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  // scanner state, one-hot
  typedef enum logic [4:0] {
    MODE_IDLE    = 5'b00001,
    MODE_COMMENT = 5'b00010,
    MODE_STRING  = 5'b00100,
    MODE_NUMBER  = 5'b01000,
    MODE_WORD    = 5'b10000
  } mode_t;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_symbol(input logic [7:0] c);
    return (c == CH_MINUS) || (c == CH_UNDER) || (c == CH_SLASH) || (c == CH_BSL);
  endfunction

endpackage

[hw/rtl/ctt_in_if.sv]
// input channel: one text byte per beat
interface ctt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

[hw/rtl/ctt_out_if.sv]
// result channel: one token per beat
interface ctt_out_if #(
  parameter int unsigned OFFSET_BITS = 32,
  parameter int unsigned LENGTH_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [3:0]             token_kind;
  logic [OFFSET_BITS-1:0] token_start;
  logic [LENGTH_BITS-1:0] token_length;
  logic                   bool_value;
  logic [15:0]            line_number;
  logic                   last_of_run;

  modport source (output valid, output token_kind, output token_start, output token_length,
                  output bool_value, output line_number, output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input token_start, input token_length,
                  input bool_value, input line_number, input last_of_run, output ready);
endinterface

[hw/rtl/config_text_tokenizer.sv]
// configuration text tokenizer top level: byte scanner and token queue
//
// Takes one text byte per clock and returns tokens (kind, start offset, length, boolean
// value, line) on the result channel. Each byte is scanned in the cycle it is accepted;
// the state registers hold the open token. A byte may close the open token and also be
// a one-character token, so it can give two tokens; these go into a four-entry queue
// that drives the result channel one token per cycle. The input is ready whenever the
// queue has room for two tokens, so a byte is taken every cycle as long as the sink keeps
// up and bytes average no more than one token each; a byte value of zero or end_of_text
// flushes the open token and restarts offsets and line counting for a new text.
module config_text_tokenizer
  import ctt_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = 32,
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  ctt_in_if.sink    in_tok,
  ctt_out_if.source out_tok
);

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = QPTR_W + 1;
  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;
  localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;

  typedef struct packed {
    logic [KIND_BITS-1:0]   kind;
    logic [OFFSET_BITS-1:0] start;
    logic [LENGTH_BITS-1:0] length;
    logic                   bval;
    logic [LINE_BITS-1:0]   line;
    logic                   last;
  } tok_t;

  // scanner state
  mode_t                  mode_r, mode_nxt;
  logic [KIND_BITS-1:0]   kind_r, kind_nxt;
  logic                   dq_r, dq_nxt;
  logic                   bs_r, bs_nxt;
  logic [OFFSET_BITS-1:0] start_r, start_nxt;
  logic [LENGTH_BITS-1:0] len_r, len_nxt;
  logic [OFFSET_BITS-1:0] off_r, off_nxt;
  logic [LINE_BITS-1:0]   line_r, line_nxt;
  logic [7:0]             fc_r [5];
  logic [7:0]             fc_nxt [5];

  // token queue
  tok_t                   q_r [QDEPTH];
  logic [QPTR_W-1:0]      wp_r, rp_r;
  logic [QCNT_W-1:0]      cnt_r;

  logic                   in_fire, out_fire;
  logic [7:0]             b;
  logic                   eot;

  // per-byte results
  logic                   a_vld, c_vld, grow_en, idle_go;
  logic [KIND_BITS-1:0]   a_kind, c_kind;
  logic                   a_bval;
  logic [KIND_BITS-1:0]   fin_kind;
  logic                   fin_bval;
  logic                   term_num, term_word;
  logic [7:0]             quote_ch;
  logic                   b_false, b_true;
  logic [7:0]             l0, l1, l2, l3, l4;
  tok_t                   tok_a, tok_c, wr0, wr1;
  logic [1:0]             n_wr;

  assign b        = in_tok.text_byte;
  assign eot      = in_tok.end_of_text || (in_tok.text_byte == CH_NUL);
  assign in_fire  = in_tok.valid && in_tok.ready;
  assign out_fire = out_tok.valid && out_tok.ready;

  // room for two tokens before a byte is taken
  assign in_tok.ready = (cnt_r <= QCNT_W'(QDEPTH - 2));

  // delimiters
  assign term_num  = (b == CH_SP) || (b == CH_TAB) || (b == CH_NL) || (b == CH_HASH) ||
                     (b == CH_SEMI);
  assign term_word = term_num || (b == CH_RBRK);
  assign quote_ch  = dq_r ? CH_DQUOT : CH_SQUOT;

  // boolean word match on the first five characters
  assign l0 = to_lower(fc_r[0]);
  assign l1 = to_lower(fc_r[1]);
  assign l2 = to_lower(fc_r[2]);
  assign l3 = to_lower(fc_r[3]);
  assign l4 = to_lower(fc_r[4]);

  always_comb begin
    b_false = ((len_r == LENGTH_BITS'(1)) && (l0 == "f" || l0 == "n")) ||
              ((len_r == LENGTH_BITS'(2)) && l0 == "n" && l1 == "o") ||
              ((len_r == LENGTH_BITS'(5)) && l0 == "f" && l1 == "a" && l2 == "l" &&
               l3 == "s" && l4 == "e");
    b_true  = ((len_r == LENGTH_BITS'(1)) && (l0 == "t" || l0 == "y")) ||
              ((len_r == LENGTH_BITS'(3)) && l0 == "y" && l1 == "e" && l2 == "s") ||
              ((len_r == LENGTH_BITS'(4)) && l0 == "t" && l1 == "r" && l2 == "u" &&
               l3 == "e");
  end

  // kind of the open token when it closes
  always_comb begin
    fin_kind = kind_r;
    fin_bval = 1'b0;
    case (mode_r)
      MODE_COMMENT: fin_kind = KIND_COMMENT;
      MODE_STRING:  fin_kind = KIND_INVALID;
      MODE_NUMBER: begin
        if (kind_r == KIND_INTEGER && len_r == LENGTH_BITS'(1) && fc_r[0] == CH_MINUS) begin
          fin_kind = KIND_INVALID;
        end
      end
      MODE_WORD: begin
        if (b_false || b_true) begin
          fin_kind = KIND_BOOL;
          fin_bval = b_true;
        end
      end
      default: fin_kind = kind_r;
    endcase
  end

  // scan one byte
  always_comb begin
    mode_nxt  = mode_r;
    kind_nxt  = kind_r;
    dq_nxt    = dq_r;
    bs_nxt    = bs_r;
    start_nxt = start_r;
    len_nxt   = len_r;
    off_nxt   = off_r;
    line_nxt  = line_r;
    for (int i = 0; i < 5; i++) begin
      fc_nxt[i] = fc_r[i];
    end
    a_vld   = 1'b0;
    a_kind  = fin_kind;
    a_bval  = fin_bval;
    c_vld   = 1'b0;
    c_kind  = KIND_NEWLINE;
    grow_en = 1'b0;
    idle_go = 1'b0;

    if (eot) begin
      // flush and start a new text
      a_vld     = (mode_r != MODE_IDLE);
      mode_nxt  = MODE_IDLE;
      kind_nxt  = '0;
      dq_nxt    = 1'b0;
      bs_nxt    = 1'b0;
      start_nxt = '0;
      len_nxt   = '0;
      off_nxt   = '0;
      line_nxt  = LINE_BITS'(1);
      for (int i = 0; i < 5; i++) begin
        fc_nxt[i] = '0;
      end
    end else begin
      off_nxt = off_r + OFFSET_BITS'(1);
      case (mode_r)
        MODE_IDLE: idle_go = 1'b1;
        MODE_COMMENT: begin
          if (b == CH_NL) begin
            a_vld    = 1'b1;
            mode_nxt = MODE_IDLE;
            idle_go  = 1'b1;
          end else begin
            grow_en = 1'b1;
          end
        end
        MODE_STRING: begin
          if (b == CH_NL) begin
            a_vld    = 1'b1;
            mode_nxt = MODE_IDLE;
            idle_go  = 1'b1;
          end else if (b == quote_ch && !bs_r) begin
            a_vld    = 1'b1;
            a_kind   = KIND_STRING;
            a_bval   = 1'b0;
            mode_nxt = MODE_IDLE;
          end else begin
            grow_en = 1'b1;
            bs_nxt  = (b == CH_BSL);
          end
        end
        MODE_NUMBER: begin
          if (term_num) begin
            a_vld    = 1'b1;
            mode_nxt = MODE_IDLE;
            idle_go  = 1'b1;
          end else begin
            grow_en = 1'b1;
            if (b == CH_DOT) begin
              kind_nxt = (kind_r == KIND_INTEGER) ? KIND_FLOAT : KIND_INVALID;
            end else if (!is_digit(b)) begin
              kind_nxt = KIND_INVALID;
            end
          end
        end
        MODE_WORD: begin
          if (term_word) begin
            a_vld    = 1'b1;
            mode_nxt = MODE_IDLE;
            idle_go  = 1'b1;
          end else begin
            grow_en = 1'b1;
            if (!(is_letter(b) || is_digit(b) || is_symbol(b))) begin
              kind_nxt = KIND_INVALID;
            end
          end
        end
        default: begin
          mode_nxt = MODE_IDLE;
          idle_go  = 1'b1;
        end
      endcase

      // extend the open token
      if (grow_en) begin
        if (len_r < LENGTH_BITS'(5)) begin
          fc_nxt[len_r[2:0]] = b;
        end
        if (len_r != LEN_MAX) begin
          len_nxt = len_r + LENGTH_BITS'(1);
        end
      end

      // byte seen between tokens
      if (idle_go) begin
        case (b)
          CH_SP, CH_TAB: begin
          end
          CH_NL: begin
            c_vld  = 1'b1;
            c_kind = KIND_NEWLINE;
            if (line_r != LINE_MAX) begin
              line_nxt = line_r + LINE_BITS'(1);
            end
          end
          CH_SEMI: begin
            c_vld  = 1'b1;
            c_kind = KIND_SEMI;
          end
          CH_LBRK: begin
            c_vld  = 1'b1;
            c_kind = KIND_LBRACK;
          end
          CH_RBRK: begin
            c_vld  = 1'b1;
            c_kind = KIND_RBRACK;
          end
          CH_EQ: begin
            c_vld  = 1'b1;
            c_kind = KIND_ASSIGN;
          end
          CH_DQUOT, CH_SQUOT: begin
            mode_nxt  = MODE_STRING;
            kind_nxt  = KIND_STRING;
            start_nxt = off_r + OFFSET_BITS'(1);
            len_nxt   = '0;
            bs_nxt    = 1'b0;
            dq_nxt    = (b == CH_DQUOT);
          end
          default: begin
            start_nxt = off_r;
            len_nxt   = LENGTH_BITS'(1);
            bs_nxt    = 1'b0;
            fc_nxt[0] = b;
            if (b == CH_HASH) begin
              mode_nxt = MODE_COMMENT;
              kind_nxt = KIND_COMMENT;
            end else if (b == CH_DOT) begin
              mode_nxt = MODE_NUMBER;
              kind_nxt = KIND_FLOAT;
            end else if (b == CH_MINUS || is_digit(b)) begin
              mode_nxt = MODE_NUMBER;
              kind_nxt = KIND_INTEGER;
            end else if (is_letter(b) || is_symbol(b)) begin
              mode_nxt = MODE_WORD;
              kind_nxt = KIND_IDENT;
            end else begin
              mode_nxt = MODE_WORD;
              kind_nxt = KIND_INVALID;
            end
          end
        endcase
      end
    end
  end

  // assemble the tokens of this byte in order
  always_comb begin
    tok_a.kind   = a_kind;
    tok_a.start  = start_r;
    tok_a.length = len_r;
    tok_a.bval   = a_bval;
    tok_a.line   = line_r;
    tok_a.last   = !c_vld;

    tok_c.kind   = c_kind;
    tok_c.start  = off_r;
    tok_c.length = LENGTH_BITS'(1);
    tok_c.bval   = 1'b0;
    tok_c.line   = line_r;
    tok_c.last   = 1'b1;

    wr0  = a_vld ? tok_a : tok_c;
    wr1  = tok_c;
    n_wr = {1'b0, a_vld} + {1'b0, c_vld};
  end

  // scanner state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      kind_r  <= '0;
      dq_r    <= 1'b0;
      bs_r    <= 1'b0;
      start_r <= '0;
      len_r   <= '0;
      off_r   <= '0;
      line_r  <= LINE_BITS'(1);
      for (int i = 0; i < 5; i++) begin
        fc_r[i] <= '0;
      end
    end else if (in_fire) begin
      mode_r  <= mode_nxt;
      kind_r  <= kind_nxt;
      dq_r    <= dq_nxt;
      bs_r    <= bs_nxt;
      start_r <= start_nxt;
      len_r   <= len_nxt;
      off_r   <= off_nxt;
      line_r  <= line_nxt;
      for (int i = 0; i < 5; i++) begin
        fc_r[i] <= fc_nxt[i];
      end
    end
  end

  // queue control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (in_fire) begin
        wp_r <= wp_r + QPTR_W'(n_wr);
      end
      if (out_fire) begin
        rp_r <= rp_r + QPTR_W'(1);
      end
      cnt_r <= cnt_r + (in_fire ? QCNT_W'(n_wr) : '0) - QCNT_W'(out_fire);
    end
  end

  // queue entries
  always_ff @(posedge clk) begin
    if (in_fire && (n_wr != 2'd0)) begin
      q_r[wp_r] <= wr0;
    end
    if (in_fire && (n_wr == 2'd2)) begin
      q_r[wp_r + QPTR_W'(1)] <= wr1;
    end
  end

  // result beat from the queue head
  assign out_tok.valid        = (cnt_r != '0);
  assign out_tok.token_kind   = q_r[rp_r].kind;
  assign out_tok.token_start  = q_r[rp_r].start;
  assign out_tok.token_length = q_r[rp_r].length;
  assign out_tok.bool_value   = q_r[rp_r].bval;
  assign out_tok.line_number  = q_r[rp_r].line;
  assign out_tok.last_of_run  = q_r[rp_r].last;

endmodule
